@@ hw/rtl/obb_pkg.sv @@
// ----------------------------------------------------------------------------
// Oriented box bounds package
// Shared constants, CORDIC types and helper functions.
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam int FracBitsDef  = 8;
  localparam int AngleBitsDef = 16;
  localparam int CordicSteps  = 16;
  localparam int TrigW        = 18;
  localparam int AddrW        = 5;
  localparam logic signed [31:0] CordicK = 32'sh26DD_3B6A;

  typedef enum logic [2:0] {
    REG_HALF_WIDTH  = 3'd0,
    REG_HALF_HEIGHT = 3'd1,
    REG_OFFSET_X    = 3'd2,
    REG_OFFSET_Y    = 3'd3,
    REG_LOCAL_ANGLE = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         q;
  } cordic_t;

  typedef struct packed {
    logic signed [TrigW-1:0] c;
    logic signed [TrigW-1:0] s;
  } trig_t;

  function automatic logic signed [31:0] atan_of(int i);
    case (i)
      0:       return 32'sh2000_0000;
      1:       return 32'sh12E4_051E;
      2:       return 32'sh09FB_385B;
      3:       return 32'sh0511_11D4;
      4:       return 32'sh028B_0D43;
      5:       return 32'sh0145_D7E1;
      6:       return 32'sh00A2_F61E;
      7:       return 32'sh0051_7C55;
      8:       return 32'sh0028_BE53;
      9:       return 32'sh0014_5F2F;
      10:      return 32'sh000A_2F98;
      11:      return 32'sh0005_17CC;
      12:      return 32'sh0002_8BE6;
      13:      return 32'sh0001_45F3;
      14:      return 32'sh0000_A2FA;
      15:      return 32'sh0000_517D;
      default: return 32'sh0;
    endcase
  endfunction

  // Phase is the angle moved to the top of a 32-bit word.
  function automatic cordic_t cordic_start(logic [31:0] phase);
    cordic_t r;
    r.q = 2'((phase + 32'h2000_0000) >> 30);
    r.z = $signed(phase - {r.q, 30'b0});
    r.x = CordicK;
    r.y = 32'sh0;
    return r;
  endfunction

  function automatic cordic_t cordic_step(cordic_t a, int i);
    cordic_t r;
    r.q = a.q;
    if (!a.z[31]) begin
      r.x = a.x - (a.y >>> i);
      r.y = a.y + (a.x >>> i);
      r.z = a.z - atan_of(i);
    end else begin
      r.x = a.x + (a.y >>> i);
      r.y = a.y - (a.x >>> i);
      r.z = a.z + atan_of(i);
    end
    return r;
  endfunction

  function automatic logic signed [TrigW-1:0] trig_round(logic signed [31:0] v);
    logic signed [32:0] t;
    t = (33'(v) + 33'sd8192) >>> 14;
    if (t > 33'sd65536) begin
      return 18'sd65536;
    end else if (t < -33'sd65536) begin
      return -18'sd65536;
    end
    return t[TrigW-1:0];
  endfunction

  function automatic trig_t cordic_finish(cordic_t a);
    logic signed [TrigW-1:0] xc;
    logic signed [TrigW-1:0] yc;
    trig_t r;
    xc = trig_round(a.x);
    yc = trig_round(a.y);
    case (a.q)
      2'd1: begin
        r.c = -yc;
        r.s = xc;
      end
      2'd2: begin
        r.c = -xc;
        r.s = -yc;
      end
      2'd3: begin
        r.c = yc;
        r.s = -xc;
      end
      default: begin
        r.c = xc;
        r.s = yc;
      end
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/obb_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// Oriented box bounds CORDIC cell
// One registered CORDIC rotation step for the object and the local angle.
// ----------------------------------------------------------------------------
module obb_cordic_cell #(
  parameter int Step = 0,
  parameter int PayW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  output logic              rdy_o,
  input  obb_pkg::cordic_t  obj_i,
  input  obb_pkg::cordic_t  loc_i,
  input  logic [PayW-1:0]   pay_i,
  output logic              vld_o,
  input  logic              rdy_i,
  output obb_pkg::cordic_t  obj_o,
  output obb_pkg::cordic_t  loc_o,
  output logic [PayW-1:0]   pay_o
);
  import obb_pkg::*;

  logic    vld_q;
  cordic_t obj_q;
  cordic_t loc_q;
  logic [PayW-1:0] pay_q;
  logic    adv;

  assign adv   = ~vld_q | rdy_i;
  assign rdy_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld_i) begin
      obj_q <= cordic_step(obj_i, Step);
      loc_q <= cordic_step(loc_i, Step);
      pay_q <= pay_i;
    end
  end

  assign vld_o = vld_q;
  assign obj_o = obj_q;
  assign loc_o = loc_q;
  assign pay_o = pay_q;

endmodule

@@ hw/rtl/obb_transform.sv @@
// ----------------------------------------------------------------------------
// Oriented box bounds transform pipeline
// Corner transform, saturation and min/max reduction in registered stages.
// ----------------------------------------------------------------------------
module obb_transform #(
  parameter int FRAC_BITS = obb_pkg::FracBitsDef,
  localparam int C = 16 + FRAC_BITS,
  localparam int S = 8 + FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  output logic                rdy_o,
  input  obb_pkg::cordic_t    obj_i,
  input  obb_pkg::cordic_t    loc_i,
  input  logic signed [S-1:0] scale_x_i,
  input  logic signed [S-1:0] scale_y_i,
  input  logic signed [C-1:0] pos_x_i,
  input  logic signed [C-1:0] pos_y_i,
  input  logic [C-2:0]        half_width_i,
  input  logic [C-2:0]        half_height_i,
  input  logic signed [C-1:0] offset_x_i,
  input  logic signed [C-1:0] offset_y_i,
  output logic                vld_o,
  input  logic                rdy_i,
  output logic signed [C-1:0] min_x_o,
  output logic signed [C-1:0] min_y_o,
  output logic signed [C-1:0] max_x_o,
  output logic signed [C-1:0] max_y_o,
  output logic signed [C-1:0] centre_x_o,
  output logic signed [C-1:0] centre_y_o,
  output logic                busy_o
);
  import obb_pkg::*;

  localparam int NumSt = 9;
  localparam int PayW  = 2 * S + 2 * C;
  localparam int PW    = C + TrigW;
  localparam int SW    = C + TrigW + 1;
  localparam int AW    = C + 4;
  localparam int MW    = AW + S;
  localparam int BW    = AW + S - FRAC_BITS;
  localparam int QW    = BW + TrigW;
  localparam int GW    = BW + TrigW + 1;
  localparam longint MaxC = (64'sd1 <<< (C - 1)) - 1;
  localparam longint MinC = -(64'sd1 <<< (C - 1));

  logic [NumSt:1] v_q;
  logic [NumSt:1] adv;
  logic [NumSt:1] vin;
  logic [NumSt:1] ld;

  always_comb begin
    for (int k = 1; k <= NumSt; k++) begin
      vin[k] = (k == 1) ? vld_i : v_q[k-1];
    end
    adv[NumSt] = ~v_q[NumSt] | rdy_i;
    for (int k = NumSt - 1; k >= 1; k--) begin
      adv[k] = ~v_q[k] | adv[k+1];
    end
    ld = adv & vin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NumSt; k++) begin
        if (adv[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  assign rdy_o  = adv[1];
  assign vld_o  = v_q[NumSt];
  assign busy_o = |v_q;

  // Object payload travels along until the translation stage.
  logic [PayW-1:0] pay_q [1:6];
  logic [PayW-1:0] pay_in;
  assign pay_in = {pos_y_i, pos_x_i, scale_y_i, scale_x_i};

  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= 6; k++) begin
      if (ld[k]) begin
        pay_q[k] <= (k == 1) ? pay_in : pay_q[k-1];
      end
    end
  end

  // Stage 1: finish both CORDIC results.
  trig_t lt_q, ot_q [1:5];
  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      lt_q     <= cordic_finish(loc_i);
      ot_q[1]  <= cordic_finish(obj_i);
    end
    for (int k = 2; k <= 5; k++) begin
      if (ld[k]) begin
        ot_q[k] <= ot_q[k-1];
      end
    end
  end

  // Stage 2: local rotation products.
  logic signed [PW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [PW-1:0] hw_e, hh_e;
  assign hw_e = PW'($signed({1'b0, half_width_i}));
  assign hh_e = PW'($signed({1'b0, half_height_i}));

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      pa_q <= hw_e * PW'(lt_q.c);
      pb_q <= hh_e * PW'(lt_q.s);
      pc_q <= hw_e * PW'(lt_q.s);
      pd_q <= hh_e * PW'(lt_q.c);
    end
  end

  // Stage 3: local corners plus offset. Point four is the centre.
  logic signed [AW-1:0] ax_d [5];
  logic signed [AW-1:0] ay_d [5];
  logic signed [AW-1:0] ax_q [5];
  logic signed [AW-1:0] ay_q [5];
  logic signed [SW-1:0] ea, eb, ec, ed;
  logic signed [SW-1:0] sx_s [4];
  logic signed [SW-1:0] sy_s [4];

  always_comb begin
    ea = SW'(pa_q);
    eb = SW'(pb_q);
    ec = SW'(pc_q);
    ed = SW'(pd_q);
    for (int i = 0; i < 4; i++) begin
      if (i == 0 || i == 3) begin
        sx_s[i] = -ea;
        sy_s[i] = -ec;
      end else begin
        sx_s[i] = ea;
        sy_s[i] = ec;
      end
      if (i < 2) begin
        sx_s[i] = sx_s[i] + eb;
        sy_s[i] = sy_s[i] - ed;
      end else begin
        sx_s[i] = sx_s[i] - eb;
        sy_s[i] = sy_s[i] + ed;
      end
      ax_d[i] = AW'((sx_s[i] + SW'(32768)) >>> 16) + AW'(offset_x_i);
      ay_d[i] = AW'((sy_s[i] + SW'(32768)) >>> 16) + AW'(offset_y_i);
    end
    ax_d[4] = AW'(offset_x_i);
    ay_d[4] = AW'(offset_y_i);
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
    end
  end

  // Stage 4: scale products.
  logic signed [S-1:0] sc_x3, sc_y3;
  logic signed [MW-1:0] mx_q [5];
  logic signed [MW-1:0] my_q [5];
  assign sc_x3 = $signed(pay_q[3][S-1:0]);
  assign sc_y3 = $signed(pay_q[3][2*S-1:S]);

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      for (int i = 0; i < 5; i++) begin
        mx_q[i] <= MW'(ax_q[i]) * MW'(sc_x3);
        my_q[i] <= MW'(ay_q[i]) * MW'(sc_y3);
      end
    end
  end

  // Stage 5: round the scaled values.
  logic signed [BW-1:0] bx_q [5];
  logic signed [BW-1:0] by_q [5];
  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      for (int i = 0; i < 5; i++) begin
        bx_q[i] <= BW'((mx_q[i] + MW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
        by_q[i] <= BW'((my_q[i] + MW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
      end
    end
  end

  // Stage 6: object rotation products.
  logic signed [QW-1:0] q1_q [5];
  logic signed [QW-1:0] q2_q [5];
  logic signed [QW-1:0] q3_q [5];
  logic signed [QW-1:0] q4_q [5];
  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      for (int i = 0; i < 5; i++) begin
        q1_q[i] <= QW'(bx_q[i]) * QW'(ot_q[5].c);
        q2_q[i] <= QW'(by_q[i]) * QW'(ot_q[5].s);
        q3_q[i] <= QW'(bx_q[i]) * QW'(ot_q[5].s);
        q4_q[i] <= QW'(by_q[i]) * QW'(ot_q[5].c);
      end
    end
  end

  // Stage 7: round, translate and saturate.
  logic signed [C-1:0] px6, py6;
  logic signed [GW-1:0] rx [5];
  logic signed [GW-1:0] ry [5];
  logic signed [C-1:0] gx_q [5];
  logic signed [C-1:0] gy_q [5];
  assign px6 = $signed(pay_q[6][2*S+C-1:2*S]);
  assign py6 = $signed(pay_q[6][2*S+2*C-1:2*S+C]);

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      rx[i] = ((GW'(q1_q[i]) - GW'(q2_q[i]) + GW'(32768)) >>> 16) + GW'(px6);
      ry[i] = ((GW'(q3_q[i]) + GW'(q4_q[i]) + GW'(32768)) >>> 16) + GW'(py6);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      for (int i = 0; i < 5; i++) begin
        if (rx[i] > GW'(MaxC)) begin
          gx_q[i] <= C'(MaxC);
        end else if (rx[i] < GW'(MinC)) begin
          gx_q[i] <= C'(MinC);
        end else begin
          gx_q[i] <= rx[i][C-1:0];
        end
        if (ry[i] > GW'(MaxC)) begin
          gy_q[i] <= C'(MaxC);
        end else if (ry[i] < GW'(MinC)) begin
          gy_q[i] <= C'(MinC);
        end else begin
          gy_q[i] <= ry[i][C-1:0];
        end
      end
    end
  end

  // Stage 8: pairwise min and max.
  logic signed [C-1:0] mnx_q [2], mny_q [2], mxx_q [2], mxy_q [2];
  logic signed [C-1:0] cx8_q, cy8_q;
  always_ff @(posedge clk_i) begin
    if (ld[8]) begin
      for (int j = 0; j < 2; j++) begin
        mnx_q[j] <= (gx_q[2*j+1] < gx_q[2*j]) ? gx_q[2*j+1] : gx_q[2*j];
        mny_q[j] <= (gy_q[2*j+1] < gy_q[2*j]) ? gy_q[2*j+1] : gy_q[2*j];
        mxx_q[j] <= (gx_q[2*j+1] > gx_q[2*j]) ? gx_q[2*j+1] : gx_q[2*j];
        mxy_q[j] <= (gy_q[2*j+1] > gy_q[2*j]) ? gy_q[2*j+1] : gy_q[2*j];
      end
      cx8_q <= gx_q[4];
      cy8_q <= gy_q[4];
    end
  end

  // Stage 9: output register.
  logic signed [C-1:0] min_x_q, min_y_q, max_x_q, max_y_q, cx_q, cy_q;
  always_ff @(posedge clk_i) begin
    if (ld[9]) begin
      min_x_q <= (mnx_q[1] < mnx_q[0]) ? mnx_q[1] : mnx_q[0];
      min_y_q <= (mny_q[1] < mny_q[0]) ? mny_q[1] : mny_q[0];
      max_x_q <= (mxx_q[1] > mxx_q[0]) ? mxx_q[1] : mxx_q[0];
      max_y_q <= (mxy_q[1] > mxy_q[0]) ? mxy_q[1] : mxy_q[0];
      cx_q    <= cx8_q;
      cy_q    <= cy8_q;
    end
  end

  assign min_x_o    = min_x_q;
  assign min_y_o    = min_y_q;
  assign max_x_o    = max_x_q;
  assign max_y_o    = max_y_q;
  assign centre_x_o = cx_q;
  assign centre_y_o = cy_q;

endmodule

@@ hw/rtl/oriented_box_bounds_top.sv @@
// ----------------------------------------------------------------------------
// Oriented box bounds top level
// Axis-aligned bounds and centre of a transformed, rotated box.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         object transform item
// m_axis    out        bounds and centre item
// apb       in         box size, offset and local angle
//
// One item per cycle is accepted while the output is not stalled. The pipeline
// is 16 CORDIC cells that turn both angles at once, then 9 transform stages,
// the last of which is the output register. Every stage holds its item while
// the next one is full, so a stalled output still lets upstream bubbles fill.
// Reset clears the valid flags and the configuration registers.
// ----------------------------------------------------------------------------
module oriented_box_bounds_top #(
  parameter int FRAC_BITS  = obb_pkg::FracBitsDef,
  parameter int ANGLE_BITS = obb_pkg::AngleBitsDef,
  localparam int C    = 16 + FRAC_BITS,
  localparam int S    = 8 + FRAC_BITS,
  localparam int InW  = 2 * S + ANGLE_BITS + 2 * C,
  localparam int InTW = ((InW + 7) / 8) * 8,
  localparam int OutW = 6 * C,
  localparam int OutTW = ((OutW + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // scale_x, scale_y, object_angle, position_x, position_y
  input  logic [InTW-1:0]           s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // min_x, min_y, max_x, max_y, centre_x, centre_y
  output logic [OutTW-1:0]          m_axis_tdata,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [obb_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import obb_pkg::*;

  localparam int PayW = 2 * S + 2 * C;

  logic [C-2:0]        half_width_q, half_height_q;
  logic signed [C-1:0] offset_x_q, offset_y_q;
  logic [ANGLE_BITS-1:0] local_angle_q;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q  <= '0;
      half_height_q <= '0;
      offset_x_q    <= '0;
      offset_y_q    <= '0;
      local_angle_q <= '0;
    end else if (wr_en) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_HALF_WIDTH:  half_width_q  <= pwdata[C-2:0];
        REG_HALF_HEIGHT: half_height_q <= pwdata[C-2:0];
        REG_OFFSET_X:    offset_x_q    <= $signed(pwdata[C-1:0]);
        REG_OFFSET_Y:    offset_y_q    <= $signed(pwdata[C-1:0]);
        REG_LOCAL_ANGLE: local_angle_q <= pwdata[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_HALF_WIDTH:  prdata = 32'(half_width_q);
      REG_HALF_HEIGHT: prdata = 32'(half_height_q);
      REG_OFFSET_X:    prdata = 32'($unsigned(offset_x_q));
      REG_OFFSET_Y:    prdata = 32'($unsigned(offset_y_q));
      REG_LOCAL_ANGLE: prdata = 32'(local_angle_q);
      default:         prdata = '0;
    endcase
  end

  // Input unpacking and CORDIC start values.
  logic [ANGLE_BITS-1:0] obj_angle;
  logic [PayW-1:0]       pay_in;
  cordic_t               obj_start, loc_start;

  assign obj_angle = s_axis_tdata[2*S+ANGLE_BITS-1:2*S];
  assign pay_in    = {s_axis_tdata[InW-1:2*S+ANGLE_BITS], s_axis_tdata[2*S-1:0]};
  assign obj_start = cordic_start({obj_angle, {(32 - ANGLE_BITS){1'b0}}});
  assign loc_start = cordic_start({local_angle_q, {(32 - ANGLE_BITS){1'b0}}});

  logic            c_vld [CordicSteps+1];
  logic            c_rdy [CordicSteps+1];
  cordic_t         c_obj [CordicSteps+1];
  cordic_t         c_loc [CordicSteps+1];
  logic [PayW-1:0] c_pay [CordicSteps+1];
  logic [CordicSteps-1:0] c_busy;

  assign c_vld[0]      = s_axis_tvalid;
  assign c_obj[0]      = obj_start;
  assign c_loc[0]      = loc_start;
  assign c_pay[0]      = pay_in;
  assign s_axis_tready = c_rdy[0];

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    obb_cordic_cell #(
      .Step (g),
      .PayW (PayW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (c_vld[g]),
      .rdy_o  (c_rdy[g]),
      .obj_i  (c_obj[g]),
      .loc_i  (c_loc[g]),
      .pay_i  (c_pay[g]),
      .vld_o  (c_vld[g+1]),
      .rdy_i  (c_rdy[g+1]),
      .obj_o  (c_obj[g+1]),
      .loc_o  (c_loc[g+1]),
      .pay_o  (c_pay[g+1])
    );
    assign c_busy[g] = c_vld[g+1];
  end

  logic signed [C-1:0] min_x, min_y, max_x, max_y, centre_x, centre_y;
  logic                xf_busy;

  obb_transform #(
    .FRAC_BITS (FRAC_BITS)
  ) u_xf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vld_i         (c_vld[CordicSteps]),
    .rdy_o         (c_rdy[CordicSteps]),
    .obj_i         (c_obj[CordicSteps]),
    .loc_i         (c_loc[CordicSteps]),
    .scale_x_i     ($signed(c_pay[CordicSteps][S-1:0])),
    .scale_y_i     ($signed(c_pay[CordicSteps][2*S-1:S])),
    .pos_x_i       ($signed(c_pay[CordicSteps][2*S+C-1:2*S])),
    .pos_y_i       ($signed(c_pay[CordicSteps][2*S+2*C-1:2*S+C])),
    .half_width_i  (half_width_q),
    .half_height_i (half_height_q),
    .offset_x_i    (offset_x_q),
    .offset_y_i    (offset_y_q),
    .vld_o         (m_axis_tvalid),
    .rdy_i         (m_axis_tready),
    .min_x_o       (min_x),
    .min_y_o       (min_y),
    .max_x_o       (max_x),
    .max_y_o       (max_y),
    .centre_x_o    (centre_x),
    .centre_y_o    (centre_y),
    .busy_o        (xf_busy)
  );

  assign m_axis_tdata = OutTW'({centre_y, centre_x, max_y, max_x, min_y, min_x});

  // An empty output stage means every stage can move, so the input is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output stage is empty");

  // With nothing in flight no result may appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_busy == '0) && !xf_busy |=> !m_axis_tvalid)
    else $error("result item appeared with an empty pipeline");

  // The output stage is part of the transform busy flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> xf_busy)
    else $error("output valid without transform busy");

endmodule

@@ sim/tb_oriented_box_bounds_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oriented box bounds testbench
// Streams object transforms through the block under random stalls, computes
// the expected bounds and centre of each item with an independent fixed-point
// model and compares every result field by field.
// ----------------------------------------------------------------------------
class bounds_scoreboard;
  typedef struct {
    logic [23:0] min_x, min_y, max_x, max_y, cen_x, cen_y;
  } bounds_t;

  bounds_t pending[$];
  longint hw, hh, ox, oy;
  logic [15:0] lang;
  int errors;

  function longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function longint rnd(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function void trig(logic [15:0] ang, output longint c, output longint s);
    logic [31:0] ph;
    logic [1:0] q;
    longint z, x, y, t;
    longint at[16];
    at = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
           32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
           32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
           32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
    ph = {ang, 16'h0};
    q = 2'((ph + 32'h20000000) >> 30);
    z = longint'($signed(ph - {q, 30'b0}));
    x = 64'h26DD3B6A;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        t = x - asr(y, i); y = y + asr(x, i); z -= at[i];
      end else begin
        t = x + asr(y, i); y = y - asr(x, i); z += at[i];
      end
      x = t;
    end
    x = rnd(x, 14);
    y = rnd(y, 14);
    if (x > 65536) x = 65536;
    if (x < -65536) x = -65536;
    if (y > 65536) y = 65536;
    if (y < -65536) y = -65536;
    case (q)
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      2'd3: begin c = y; s = -x; end
      default: begin c = x; s = y; end
    endcase
  endfunction

  function longint clamp(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function void note_transform(logic [95:0] d);
    longint lc, ls, oc, os, sx, sy, px, py, ax, ay, bx, by, gx, gy;
    longint mnx, mny, mxx, mxy, posx, posy;
    bounds_t b;
    trig(lang, lc, ls);
    trig(d[47:32], oc, os);
    sx = longint'($signed(d[15:0]));
    sy = longint'($signed(d[31:16]));
    posx = longint'($signed(d[71:48]));
    posy = longint'($signed(d[95:72]));
    for (int i = 0; i < 5; i++) begin
      px = (i == 4) ? 0 : (i == 0 || i == 3) ? -hw : hw;
      py = (i == 4) ? 0 : (i < 2) ? -hh : hh;
      ax = rnd(px * lc - py * ls, 16) + ox;
      ay = rnd(px * ls + py * lc, 16) + oy;
      bx = rnd(ax * sx, 8);
      by = rnd(ay * sy, 8);
      gx = clamp(rnd(bx * oc - by * os, 16) + posx);
      gy = clamp(rnd(bx * os + by * oc, 16) + posy);
      if (i == 4) begin
        b.cen_x = gx[23:0]; b.cen_y = gy[23:0];
      end else begin
        if (i == 0 || gx < mnx) mnx = gx;
        if (i == 0 || gy < mny) mny = gy;
        if (i == 0 || gx > mxx) mxx = gx;
        if (i == 0 || gy > mxy) mxy = gy;
      end
    end
    b.min_x = mnx[23:0]; b.min_y = mny[23:0];
    b.max_x = mxx[23:0]; b.max_y = mxy[23:0];
    pending.push_back(b);
  endfunction

  function void check_bounds(logic [143:0] d);
    bounds_t e;
    logic [143:0] w;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", d);
      return;
    end
    e = pending.pop_front();
    w = {e.cen_y, e.cen_x, e.max_y, e.max_x, e.min_y, e.min_x};
    for (int f = 0; f < 6; f++) begin
      if (w[f*24 +: 24] !== d[f*24 +: 24]) begin
        errors++;
        if (errors <= 10)
          $display("field %0d: expected %h, got %h", f, w[f*24 +: 24], d[f*24 +: 24]);
      end
    end
  endfunction
endclass

module tb_oriented_box_bounds_top;
  import obb_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [143:0] m_axis_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bounds_scoreboard board = new();
  int idle_cycles;
  bit calm;

  oriented_box_bounds_top uut (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) board.check_bounds(m_axis_tdata);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > 20000) begin
      $display("tb_oriented_box_bounds_top: FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 0;
        n = $urandom_range(1, 15);
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready <= 1;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= AddrW'(4 * idx); pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_HALF_WIDTH:  board.hw = v[22:0];
      REG_HALF_HEIGHT: board.hh = v[22:0];
      REG_OFFSET_X:    board.ox = longint'($signed(v[23:0]));
      REG_OFFSET_Y:    board.oy = longint'($signed(v[23:0]));
      default:         board.lang = v[15:0];
    endcase
  endtask

  task automatic send_transform(logic [95:0] d);
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 0;
      n = $urandom_range(1, 15);
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_transform(d);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic logic [95:0] rand_transform(bit smallish);
    logic [95:0] d;
    d = {$urandom, $urandom, $urandom};
    if (smallish) begin
      d[15:0] = 16'($signed($urandom_range(0, 1024)) - 512);
      d[31:16] = 16'($signed($urandom_range(0, 1024)) - 512);
    end
    return d;
  endfunction

  task automatic configure(int mode);
    logic [31:0] r[5];
    if (mode == 0) r = '{32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF, 32'h800000, 32'hFFFF};
    else if (mode == 1) r = '{0, 0, 32'h800000, 32'h7FFFFF, 0};
    else r = '{$urandom_range(0, 32'h3FFFF), $urandom_range(0, 32'h3FFFF),
               $urandom, $urandom, $urandom};
    write_reg(REG_HALF_WIDTH, r[0]);
    write_reg(REG_HALF_HEIGHT, r[1]);
    write_reg(REG_OFFSET_X, r[2]);
    write_reg(REG_OFFSET_Y, r[3]);
    write_reg(REG_LOCAL_ANGLE, r[4]);
  endtask

  initial begin
    logic [15:0] angs[8];
    angs = '{16'h0000, 16'h2000, 16'h4000, 16'h6000, 16'h8000, 16'hC000, 16'hE000, 16'hFFFF};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1;
    configure(2);
    for (int i = 0; i < 8; i++)
      send_transform({24'h000100, 24'hFFFF00, angs[i], 16'h0100, 16'h0100});
    send_transform({24'h7FFFFF, 24'h800000, 16'h0000, 16'h7FFF, 16'h8000});
    send_transform({24'h800000, 24'h7FFFFF, 16'h1234, 16'h8000, 16'h7FFF});
    send_transform('0);
    drain();
    configure(0);
    send_transform({24'h7FFFFF, 24'h7FFFFF, 16'h4000, 16'h7FFF, 16'h7FFF});
    send_transform({24'h800000, 24'h800000, 16'hC000, 16'h8000, 16'h8000});
    send_transform({$urandom, $urandom, $urandom});
    drain();
    configure(1);
    send_transform({24'h000000, 24'h000000, 16'h8000, 16'hFF00, 16'h0100});
    send_transform({$urandom, $urandom, $urandom});
    for (int p = 0; p < 6; p++) begin
      drain();
      configure(2);
      for (int i = 0; i < 230; i++) send_transform(rand_transform($urandom_range(0, 3) != 0));
    end
    drain();
    configure(2);
    calm = 1;
    for (int i = 0; i < 150; i++) send_transform(rand_transform(1));
    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_oriented_box_bounds_top: PASS");
    else
      $display("tb_oriented_box_bounds_top: FAIL");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/obb_pkg.sv
hw/rtl/obb_cordic_cell.sv
hw/rtl/obb_transform.sv
hw/rtl/oriented_box_bounds_top.sv
sim/tb_oriented_box_bounds_top.sv
